>>> rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PRM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion violated");

// antecedent in one cycle implies consequent in the next
`define PRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

>>> rtl/prm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_LOW          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LOW        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HIGH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_HIGH         = 3'd4;

    localparam int LIMIT_W = 10;
    localparam int RATE_W  = 32;
    localparam int PERIOD_W = 24;
    localparam int SEG_W   = 8;
    localparam int ZONE_W  = 2;
    localparam int DIGIT_W = 4;
    localparam int OUT_DATA_W = 88;

    localparam logic [RATE_W-1:0]  TPM_RESET        = 32'd110592000;
    localparam logic [LIMIT_W-1:0] RED_LOW_RESET    = 10'd30;
    localparam logic [LIMIT_W-1:0] GREEN_LOW_RESET  = 10'd50;
    localparam logic [LIMIT_W-1:0] GREEN_HIGH_RESET = 10'd90;
    localparam logic [LIMIT_W-1:0] RED_HIGH_RESET   = 10'd170;

    // depth of the period queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
    localparam logic [RATE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    localparam logic [ZONE_W-1:0] ZONE_GREEN  = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_YELLOW = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_RED    = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0]  ticks_per_minute;
        logic [LIMIT_W-1:0] red_low_limit;
        logic [LIMIT_W-1:0] green_low_limit;
        logic [LIMIT_W-1:0] green_high_limit;
        logic [LIMIT_W-1:0] red_high_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_WAIT_LOW,
        PH_WAIT_RISE,
        PH_COUNT_LOW,
        PH_COUNT_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DIGIT,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // active-low segment pattern of one decimal digit
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h40;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'h8C;
            4'd3:    code = 8'hA8;
            4'd4:    code = 8'h39;
            4'd5:    code = 8'h2A;
            4'd6:    code = 8'h02;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h00;
            4'd9:    code = 8'h30;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

    function automatic logic [ZONE_W-1:0] zone_of(input logic [RATE_W-1:0] rate,
                                                 input cfg_t cfg);
        logic [ZONE_W-1:0] z;
        if (rate >= RATE_W'(cfg.green_low_limit) && rate <= RATE_W'(cfg.green_high_limit))
            z = ZONE_GREEN;
        else if (rate < RATE_W'(cfg.green_low_limit))
            z = (rate < RATE_W'(cfg.red_low_limit)) ? ZONE_RED : ZONE_YELLOW;
        else
            z = (rate <= RATE_W'(cfg.red_high_limit)) ? ZONE_YELLOW : ZONE_RED;
        return z;
    endfunction

endpackage

`default_nettype wire

>>> rtl/prm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module prm_front #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_fire,
    input  wire logic                  pulse_level,
    output logic                       push,
    output logic [COUNT_BITS-1:0]      push_period
);

    prm_pkg::phase_t         phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [COUNT_BITS-1:0]   count_inc;

    assign count_inc = count_reg + 1'b1;

    // next state and counter
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                prm_pkg::PH_WAIT_LOW:
                begin
                    if (!pulse_level)
                        phase_next = prm_pkg::PH_WAIT_RISE;
                end
                prm_pkg::PH_WAIT_RISE:
                begin
                    if (pulse_level)
                    begin
                        count_next = '0;
                        phase_next = prm_pkg::PH_COUNT_LOW;
                    end
                end
                prm_pkg::PH_COUNT_LOW:
                begin
                    count_next = count_inc;
                    if (!pulse_level)
                        phase_next = prm_pkg::PH_COUNT_HIGH;
                end
                prm_pkg::PH_COUNT_HIGH:
                begin
                    count_next = count_inc;
                    if (pulse_level)
                    begin
                        count_next = '0;
                        phase_next = prm_pkg::PH_WAIT_LOW;
                    end
                end
                default:
                begin
                    phase_next = prm_pkg::PH_WAIT_LOW;
                end
            endcase
        end
    end

    // period ends on the rising edge seen while counting
    always_comb
    begin
        push        = in_fire && pulse_level && (phase_reg == prm_pkg::PH_COUNT_HIGH);
        push_period = count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= prm_pkg::PH_WAIT_LOW;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/prm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module prm_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       pop_data,
    output prm_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `PRM_ASSERT(a_no_overflow, clk, rst_n, !(push && status.full))
    `PRM_ASSERT(a_no_underflow, clk, rst_n, !(pop && status.empty))
    `PRM_ASSERT(a_count_bound, clk, rst_n, cnt_reg <= CNT_W'(DEPTH))
    `PRM_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

`default_nettype wire

>>> rtl/prm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module prm_back #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire prm_pkg::cfg_t                cfg,
    input  wire logic                         q_valid,
    input  wire logic [COUNT_BITS-1:0]        q_period,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [prm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int RW = prm_pkg::RATE_W;
    localparam int DW = prm_pkg::DIGIT_W;
    localparam int STEP_W = $clog2(RW);

    prm_pkg::back_state_t state_reg, state_next;

    logic [RW-1:0]                 rem_reg, rem_next;
    logic [RW-1:0]                 quot_reg, quot_next;
    logic [RW-1:0]                 div_reg, div_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [RW-1:0]                 x_reg, x_next;
    logic [1:0]                    dig_reg, dig_next;
    logic [DW-1:0]                 ones_reg, ones_next;
    logic [DW-1:0]                 tens_reg, tens_next;
    logic [DW-1:0]                 hund_reg, hund_next;
    logic [prm_pkg::PERIOD_W-1:0]  period_reg, period_next;

    logic [RW:0]    rem_shift;
    logic           rem_ge;
    logic [2*RW-1:0] prod;
    logic [RW-1:0]  x_div10;
    logic [DW-1:0]  x_digit;
    logic [RW-1:0]  q_ext;

    assign q_ext     = RW'(q_period);
    assign rem_shift = {rem_reg, quot_reg[RW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign prod      = (2*RW)'(x_reg) * (2*RW)'(prm_pkg::RECIP_TEN);
    assign x_div10   = RW'(prod >> prm_pkg::RECIP_SHIFT);
    assign x_digit   = DW'(x_reg - ((x_div10 << 3) + (x_div10 << 1)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prm_pkg::BK_IDLE:  if (q_valid) state_next = prm_pkg::BK_DIV;
            prm_pkg::BK_DIV:   if (step_reg == '0) state_next = prm_pkg::BK_DIGIT;
            prm_pkg::BK_DIGIT: if (dig_reg == 2'd2) state_next = prm_pkg::BK_OUT;
            prm_pkg::BK_OUT:   if (m_tready) state_next = prm_pkg::BK_IDLE;
            default:           state_next = prm_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop      = (state_reg == prm_pkg::BK_IDLE) && q_valid;
        m_tvalid = (state_reg == prm_pkg::BK_OUT);
        m_tdata  = {6'b0,
                    prm_pkg::zone_of(quot_reg, cfg),
                    (hund_reg == '0) ? prm_pkg::SEG_BLANK : prm_pkg::seg_code(hund_reg),
                    prm_pkg::seg_code(tens_reg),
                    prm_pkg::seg_code(ones_reg),
                    quot_reg,
                    period_reg};
    end

    // datapath: restoring divide, then one decimal digit per cycle
    always_comb
    begin
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        div_next    = div_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        dig_next    = dig_reg;
        ones_next   = ones_reg;
        tens_next   = tens_reg;
        hund_next   = hund_reg;
        period_next = period_reg;
        unique case (state_reg)
            prm_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    period_next = prm_pkg::PERIOD_W'(q_period);
                    div_next    = (q_ext == '0) ? RW'(1) : q_ext;
                    quot_next   = cfg.ticks_per_minute;
                    rem_next    = '0;
                    step_next   = STEP_W'(RW - 1);
                end
            end
            prm_pkg::BK_DIV:
            begin
                // partial remainder stays below the divisor
                rem_next  = rem_ge ? RW'(rem_shift - {1'b0, div_reg}) : rem_shift[RW-1:0];
                quot_next = {quot_reg[RW-2:0], rem_ge};
                step_next = step_reg - 1'b1;
                x_next    = {quot_reg[RW-2:0], rem_ge};
                dig_next  = '0;
            end
            prm_pkg::BK_DIGIT:
            begin
                x_next   = x_div10;
                dig_next = dig_reg + 1'b1;
                case (dig_reg)
                    2'd0:    ones_next = x_digit;
                    2'd1:    tens_next = x_digit;
                    default: hund_next = x_digit;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= prm_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        div_reg    <= div_next;
        step_reg   <= step_next;
        x_reg      <= x_next;
        dig_reg    <= dig_next;
        ones_reg   <= ones_next;
        tens_reg   <= tens_next;
        hund_reg   <= hund_next;
        period_reg <= period_next;
    end

endmodule

`default_nettype wire

>>> rtl/pulse_rate_meter_seven_seg.sv
// pulse rate meter with seven-segment digits and a three-color zone
// slave stream: one word per timer tick, s_tdata[0] is the sampled pulse level
// master stream: one word per measured period (rising edge to rising edge)
// config channel: cfg_index selects ticks_per_minute (0), red_low (1),
//   green_low (2), green_high (3), red_high (4); other indexes are ignored,
//   cfg_ready is always high, write only while no period is in flight
// the front phase machine takes a word every cycle while the queue has
//   room and drops finished periods into a two-entry queue; the back end
//   divides and formats them: after the word carrying the ending edge the
//   period is popped, divided bit-serially (radix-2), then split into digits
// the back end takes a new period only once the last result word is taken;
//   input ticks keep flowing at one per cycle while the queue has room
// when the receiver stalls the result word holds in the output register,
//   periods collect in the queue, and s_tready drops once it is full
// reset: all limits and ticks_per_minute return to defaults, the phase
//   machine waits for a low level, queue and output go empty
`timescale 1ns / 1ps
`default_nettype none

module pulse_rate_meter_seven_seg #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [0] pulse_level, [7:1] zero
    // master stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [23:0] period_ticks, [55:24] rate_per_minute, [63:56] seg_ones,
    // [71:64] seg_tens, [79:72] seg_hundreds, [81:80] zone, [87:82] zero
    output logic [prm_pkg::OUT_DATA_W-1:0]          m_tdata,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [prm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                        cfg_data
);

    prm_pkg::cfg_t          cfg_reg, cfg_next;
    prm_pkg::queue_status_t q_status;
    logic                   in_fire;
    logic                   push;
    logic [COUNT_BITS-1:0]  push_period;
    logic                   pop;
    logic [COUNT_BITS-1:0]  pop_period;

    // inputs pause only when the period queue has no room
    assign s_tready  = !q_status.full;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // register file, values masked to register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                prm_pkg::CFG_TICKS_PER_MINUTE: cfg_next.ticks_per_minute = cfg_data;
                prm_pkg::CFG_RED_LOW:    cfg_next.red_low_limit    = cfg_data[9:0];
                prm_pkg::CFG_GREEN_LOW:  cfg_next.green_low_limit  = cfg_data[9:0];
                prm_pkg::CFG_GREEN_HIGH: cfg_next.green_high_limit = cfg_data[9:0];
                prm_pkg::CFG_RED_HIGH:   cfg_next.red_high_limit   = cfg_data[9:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_minute <= prm_pkg::TPM_RESET;
            cfg_reg.red_low_limit    <= prm_pkg::RED_LOW_RESET;
            cfg_reg.green_low_limit  <= prm_pkg::GREEN_LOW_RESET;
            cfg_reg.green_high_limit <= prm_pkg::GREEN_HIGH_RESET;
            cfg_reg.red_high_limit   <= prm_pkg::RED_HIGH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // edge tracking and tick counting
    prm_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .pulse_level (s_tdata[0]),
        .push        (push),
        .push_period (push_period)
    );

    // finished periods waiting for the divider
    prm_queue #(
        .WIDTH (COUNT_BITS),
        .DEPTH (prm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_period),
        .pop       (pop),
        .pop_data  (pop_period),
        .status    (q_status)
    );

    // rate divide, digit split, segment and zone lookup
    prm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (!q_status.empty),
        .q_period (pop_period),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> tb/sv/pulse_rate_meter_seven_seg_test.sv
`timescale 1ns / 1ps

module pulse_rate_meter_seven_seg_test;

    // field widths of the block
    localparam int CFG_IDX_W  = prm_pkg::CFG_IDX_W;
    localparam int LIMIT_W    = prm_pkg::LIMIT_W;
    localparam int RATE_W     = prm_pkg::RATE_W;
    localparam int PERIOD_W   = prm_pkg::PERIOD_W;
    localparam int SEG_W      = prm_pkg::SEG_W;
    localparam int ZONE_W     = prm_pkg::ZONE_W;
    localparam int OUT_DATA_W = prm_pkg::OUT_DATA_W;

    // indexes above the last register, written to show they change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    // cycles to let the back end finish before touching the registers
    localparam int SETTLE_CYCLES = 40;
    // long receiver hold-off that fills the period queue
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT = 10;

    // one measured period as it leaves the block
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [RATE_W-1:0]   rate;
        logic [SEG_W-1:0]    ones;
        logic [SEG_W-1:0]    tens;
        logic [SEG_W-1:0]    hundreds;
        logic [ZONE_W-1:0]   zone;
    } reading_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = 8'h00;     // [0] pulse_level, [7:1] zero
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [23:0] period_ticks, [55:24] rate_per_minute, [63:56] seg_ones,
    // [71:64] seg_tens, [79:72] seg_hundreds, [81:80] zone, [87:82] zero
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [31:0]             cfg_data = '0;

    // shadow of the meter: settings, phase machine and tick counter
    prm_pkg::cfg_t           meter_cfg;
    prm_pkg::phase_t         meter_phase;
    logic [PERIOD_W-1:0]     tick_total;

    // readings predicted but not yet seen on the master side
    reading_t                expected_readings [$];
    // pulse levels waiting for the driver
    logic                    tick_queue [$];

    int  ticks_queued = 0;
    int  ticks_accepted = 0;
    int  readings_checked = 0;
    int  register_writes = 0;
    int  input_stalls = 0;
    int  fail_count = 0;
    int  send_gap = 0;
    int  out_stall = 0;
    int  hold_left = 0;
    int  holds_asked = 0;
    int  holds_served = 0;
    bit  calm = 1'b0;
    bit  slot_busy;

    pulse_rate_meter_seven_seg u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void restore_defaults();
        meter_cfg.ticks_per_minute = prm_pkg::TPM_RESET;
        meter_cfg.red_low_limit    = prm_pkg::RED_LOW_RESET;
        meter_cfg.green_low_limit  = prm_pkg::GREEN_LOW_RESET;
        meter_cfg.green_high_limit = prm_pkg::GREEN_HIGH_RESET;
        meter_cfg.red_high_limit   = prm_pkg::RED_HIGH_RESET;
        meter_phase = prm_pkg::PH_WAIT_LOW;
        tick_total  = '0;
    endfunction

    // limits keep only their low bits, unknown indexes are dropped
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [31:0] value);
        case (idx)
            prm_pkg::CFG_TICKS_PER_MINUTE: meter_cfg.ticks_per_minute = value;
            prm_pkg::CFG_RED_LOW:    meter_cfg.red_low_limit    = value[LIMIT_W-1:0];
            prm_pkg::CFG_GREEN_LOW:  meter_cfg.green_low_limit  = value[LIMIT_W-1:0];
            prm_pkg::CFG_GREEN_HIGH: meter_cfg.green_high_limit = value[LIMIT_W-1:0];
            prm_pkg::CFG_RED_HIGH:   meter_cfg.red_high_limit   = value[LIMIT_W-1:0];
            default:                 ;
        endcase
    endfunction

    // active-low segments, bit order of the display wiring
    function automatic logic [SEG_W-1:0] digit_pattern(input logic [RATE_W-1:0] d);
        logic [SEG_W-1:0] p;
        case (d)
            0:       p = 8'b0100_0000;
            1:       p = 8'b1111_1001;
            2:       p = 8'b1000_1100;
            3:       p = 8'b1010_1000;
            4:       p = 8'b0011_1001;
            5:       p = 8'b0010_1010;
            6:       p = 8'b0000_0010;
            7:       p = 8'b1111_1000;
            8:       p = 8'b0000_0000;
            default: p = 8'b0011_0000;
        endcase
        return p;
    endfunction

    // green band first, then the side of the band decides yellow or red
    function automatic logic [ZONE_W-1:0] classify_rate(input logic [RATE_W-1:0] rate);
        logic [RATE_W-1:0] red_low;
        logic [RATE_W-1:0] green_low;
        logic [RATE_W-1:0] green_high;
        logic [RATE_W-1:0] red_high;
        red_low    = RATE_W'(meter_cfg.red_low_limit);
        green_low  = RATE_W'(meter_cfg.green_low_limit);
        green_high = RATE_W'(meter_cfg.green_high_limit);
        red_high   = RATE_W'(meter_cfg.red_high_limit);
        if (rate >= green_low && rate <= green_high)
            return prm_pkg::ZONE_GREEN;
        if (rate < green_low)
            return (rate < red_low) ? prm_pkg::ZONE_RED : prm_pkg::ZONE_YELLOW;
        return (rate <= red_high) ? prm_pkg::ZONE_YELLOW : prm_pkg::ZONE_RED;
    endfunction

    // advance the phase machine by one tick, queue a reading at each period
    function automatic void predict_tick(input logic level);
        reading_t          r;
        logic [RATE_W-1:0] divisor;
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] hundreds;
        case (meter_phase)
            prm_pkg::PH_WAIT_LOW:
            begin
                if (!level)
                    meter_phase = prm_pkg::PH_WAIT_RISE;
            end
            prm_pkg::PH_WAIT_RISE:
            begin
                // the starting edge clears the count
                if (level)
                begin
                    tick_total  = '0;
                    meter_phase = prm_pkg::PH_COUNT_LOW;
                end
            end
            prm_pkg::PH_COUNT_LOW:
            begin
                tick_total = tick_total + 1'b1;
                if (!level)
                    meter_phase = prm_pkg::PH_COUNT_HIGH;
            end
            default:
            begin
                tick_total = tick_total + 1'b1;
                if (level)
                begin
                    // a wrapped count of zero divides as one
                    divisor  = (tick_total == '0) ? 1 : RATE_W'(tick_total);
                    rate     = meter_cfg.ticks_per_minute / divisor;
                    hundreds = (rate / 100) % 10;
                    r.period   = tick_total;
                    r.rate     = rate;
                    r.ones     = digit_pattern(rate % 10);
                    r.tens     = digit_pattern((rate / 10) % 10);
                    r.hundreds = (hundreds == 0) ? prm_pkg::SEG_BLANK
                                                 : digit_pattern(hundreds);
                    r.zone     = classify_rate(rate);
                    expected_readings.push_back(r);
                    meter_phase = prm_pkg::PH_WAIT_LOW;
                    tick_total  = '0;
                end
            end
        endcase
    endfunction

    // compare one result word with the oldest prediction
    function automatic void check_reading(input logic [OUT_DATA_W-1:0] word);
        reading_t got;
        reading_t want;
        bit       bad;
        got.period   = word[23:0];
        got.rate     = word[55:24];
        got.ones     = word[63:56];
        got.tens     = word[71:64];
        got.hundreds = word[79:72];
        got.zone     = word[81:80];
        if (expected_readings.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("[%0t] unexpected result word %h", $realtime, word);
            return;
        end
        want = expected_readings.pop_front();
        readings_checked++;
        bad = (got.period !== want.period) || (got.rate !== want.rate)
            || (got.ones !== want.ones) || (got.tens !== want.tens)
            || (got.hundreds !== want.hundreds) || (got.zone !== want.zone);
        if (bad)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
            begin
                $display("[%0t] mismatch: expected period %0d rate %0d seg %h %h %h zone %0d",
                         $realtime, want.period, want.rate, want.hundreds, want.tens,
                         want.ones, want.zone);
                $display("[%0t]           actual period %0d rate %0d seg %h %h %h zone %0d",
                         $realtime, got.period, got.rate, got.hundreds, got.tens,
                         got.ones, got.zone);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // slave side: one pulse level per word, random idle bursts
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            slot_busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_tick(s_tdata[0]);
                ticks_accepted++;
                slot_busy = 1'b0;
            end
            else if (s_tvalid)
            begin
                // block full: word held until the queue drains
                input_stalls++;
            end
            if (!slot_busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (tick_queue.size() != 0 && !calm && $urandom_range(0, 5) == 0)
                begin
                    // idle burst: valid drops now and stays low while send_gap counts down
                    send_gap = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, tick_queue.pop_front()};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // master side: check every accepted word, random stalls
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_reading(m_tdata);
            if (out_stall > 0)
                out_stall--;
            else if (!calm && $urandom_range(0, 5) == 0)
                out_stall = $urandom_range(1, 6);
            m_tready <= (hold_left == 0) && (out_stall == 0);
        end
    end

    // long hold-off on the master side, counted here on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            hold_left <= HOLD_CYCLES;
            holds_served++;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_level(input logic level);
        tick_queue.push_back(level);
        ticks_queued++;
    endfunction

    function automatic void push_run(input logic level, input int count);
        repeat (count) push_level(level);
    endfunction

    // levels listed in sending order, one character per tick
    function automatic void push_pattern(input string levels);
        for (int i = 0; i < levels.len(); i++)
            push_level(levels[i] == "1");
    endfunction

    // mostly short runs, some medium, a few long ones
    function automatic int pick_run();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return $urandom_range(40, 400);
        if (r < 4)
            return $urandom_range(8, 40);
        return $urandom_range(1, 8);
    endfunction

    // pulse trains with random widths, mixed with noise and torn runs
    function automatic void queue_pulse_train(input int count);
        int added;
        int kind;
        int low_len;
        int high_len;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                low_len = $urandom_range(1, 8);
                repeat (low_len) push_level(1'($urandom_range(0, 1)));
                added += low_len;
            end
            else if (kind == 1)
            begin
                low_len = pick_run();
                push_run(1'($urandom_range(0, 1)), low_len);
                added += low_len;
            end
            else
            begin
                low_len  = pick_run();
                high_len = pick_run();
                push_run(1'b0, low_len);
                push_run(1'b1, high_len);
                added += low_len + high_len;
            end
        end
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
        register_writes++;
        cfg_valid <= 1'b0;
    endtask

    // limit write with random junk above the register width
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
        write_register(idx, ($urandom & 32'hFFFF_FC00) | 32'(value));
    endtask

    task automatic write_all(input logic [31:0] tpm, input logic [LIMIT_W-1:0] red_low,
                             input logic [LIMIT_W-1:0] green_low,
                             input logic [LIMIT_W-1:0] green_high,
                             input logic [LIMIT_W-1:0] red_high);
        write_register(prm_pkg::CFG_TICKS_PER_MINUTE, tpm);
        write_limit(prm_pkg::CFG_RED_LOW, red_low);
        write_limit(prm_pkg::CFG_GREEN_LOW, green_low);
        write_limit(prm_pkg::CFG_GREEN_HIGH, green_high);
        write_limit(prm_pkg::CFG_RED_HIGH, red_high);
    endtask

    // random settings, limits usually in order, dividend over several decades
    task automatic randomize_settings(input bit ordered);
        logic [31:0]        tpm;
        logic [LIMIT_W-1:0] lim [0:3];
        logic [LIMIT_W-1:0] swap;
        case ($urandom_range(0, 3))
            0:       tpm = $urandom;
            1:       tpm = $urandom_range(200, 20000);
            2:       tpm = $urandom_range(20000, 300000);
            default: tpm = $urandom_range(1, 200);
        endcase
        for (int i = 0; i < 4; i++)
            lim[i] = LIMIT_W'($urandom_range(0, 1023));
        if (ordered)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3 - i; j++)
                    if (lim[j] > lim[j + 1])
                    begin
                        swap = lim[j];
                        lim[j] = lim[j + 1];
                        lim[j + 1] = swap;
                    end
        end
        write_all(tpm, lim[0], lim[1], lim[2], lim[3]);
        if ($urandom_range(0, 2) == 0)
            write_register(CFG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
    endtask

    // wait for the driver to empty and every reading to come back
    task automatic settle();
        while (ticks_accepted != ticks_queued || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        restore_defaults();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // default settings: shortest period, high while counting, ignored
        // high before the first low, back-to-back periods
        push_pattern("11010101110001101101");
        queue_pulse_train(80);
        settle();

        // largest dividend, all-zero and all-one limits: huge rates, red
        write_all(32'hFFFF_FFFF, 10'd0, 10'd0, 10'd1023, 10'd1023);
        write_register(prm_pkg::CFG_GREEN_HIGH, 32'hFFFF_FFFF);
        push_pattern("0101");
        queue_pulse_train(25);
        settle();

        // zero dividend: rate zero everywhere, zero limits make it green
        write_all(32'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        push_pattern("010011");
        queue_pulse_train(25);
        settle();

        // limits out of order, tiny dividend
        write_all(32'd1, 10'd1023, 10'd1023, 10'd0, 10'd0);
        push_pattern("0101");
        queue_pulse_train(25);
        settle();

        // random settings, mostly ordered limits
        repeat (4)
        begin
            randomize_settings($urandom_range(0, 3) != 0);
            queue_pulse_train(80);
            settle();
        end

        // receiver holds off while the sender keeps pushing short periods,
        // so the queue fills and the slave side stalls
        randomize_settings(1'b1);
        holds_asked++;
        repeat (80) push_pattern("01");
        settle();

        // one long period, well past the short runs of the pulse trains
        write_all(prm_pkg::TPM_RESET, prm_pkg::RED_LOW_RESET, prm_pkg::GREEN_LOW_RESET,
                  prm_pkg::GREEN_HIGH_RESET, prm_pkg::RED_HIGH_RESET);
        push_pattern("01");
        push_run(1'b1, 64);
        push_run(1'b0, 128 + $urandom_range(0, 31));
        push_level(1'b1);
        settle();

        // closing stretch with no idling on either side
        calm = 1'b1;
        randomize_settings(1'b1);
        queue_pulse_train(100);
        settle();

        fail_count += expected_readings.size();
        $display("run covered %0d pulse ticks, %0d measured periods, %0d register writes",
                 ticks_accepted, readings_checked, register_writes);
        $display("slave side stalled for %0d cycles under output back-pressure", input_stalls);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("timeout with %0d readings outstanding", expected_readings.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
